// File: src/mpq_pkg.sv
`timescale 1ns / 1ps
package mpq_pkg;

  // default geometry
  localparam int DEPTH_DEF    = 256;
  localparam int KEY_BITS_DEF = 32;
  localparam int TAG_BITS_DEF = 9;

  // configuration register file
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 1;
  localparam logic [REG_IDX_BITS-1:0] REG_CAPACITY_LIMIT = 1'b0;

  localparam int CAP_BITS = 9;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 9'd256;

  // request opcodes
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // insert the new entry at its sorted place
    logic del;  // drop the head, every cell pulls from its successor
  } mpq_cmd_t;

endpackage

// File: src/mpq_if.sv
`timescale 1ns / 1ps
interface mpq_cmd_if #(
  parameter int KEY_BITS = mpq_pkg::KEY_BITS_DEF,
  parameter int TAG_BITS = mpq_pkg::TAG_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                operation;
  logic [KEY_BITS-1:0] entry_key;
  logic [TAG_BITS-1:0] entry_tag;

  modport source (output valid, operation, entry_key, entry_tag, input ready);
  modport sink (input valid, operation, entry_key, entry_tag, output ready);
endinterface

interface mpq_res_if #(
  parameter int KEY_BITS = mpq_pkg::KEY_BITS_DEF,
  parameter int TAG_BITS = mpq_pkg::TAG_BITS_DEF,
  parameter int CNT_BITS = $clog2(mpq_pkg::DEPTH_DEF + 1)
);
  logic                valid;
  logic                ready;
  logic                accepted;
  logic [KEY_BITS-1:0] out_key;
  logic [TAG_BITS-1:0] out_tag;
  logic [CNT_BITS-1:0] count;
  logic                is_empty;
  logic                is_full;

  modport source (output valid, accepted, out_key, out_tag, count, is_empty, is_full,
                  input ready);
  modport sink (input valid, accepted, out_key, out_tag, count, is_empty, is_full,
                output ready);
endinterface

// File: src/mpq_cell.sv
`timescale 1ns / 1ps
module mpq_cell #(
  parameter int KEY_BITS = mpq_pkg::KEY_BITS_DEF,
  parameter int TAG_BITS = mpq_pkg::TAG_BITS_DEF
) (
  input  logic                clk,
  input  mpq_pkg::mpq_cmd_t   cmd,
  input  logic                occupied,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [TAG_BITS-1:0] new_tag,
  input  logic [KEY_BITS-1:0] prev_key,
  input  logic [TAG_BITS-1:0] prev_tag,
  input  logic                prev_flag,
  input  logic [KEY_BITS-1:0] next_key,
  input  logic [TAG_BITS-1:0] next_tag,
  output logic [KEY_BITS-1:0] key,
  output logic [TAG_BITS-1:0] tag,
  output logic                flag
);
  import mpq_pkg::*;

  // new entry goes ahead of every entry with an equal or larger key
  assign flag = !occupied || (new_key <= key);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (flag) begin
        key <= prev_flag ? prev_key : new_key;
        tag <= prev_flag ? prev_tag : new_tag;
      end
    end else if (cmd.del) begin
      key <= next_key;
      tag <= next_tag;
    end
  end

endmodule

// File: src/min_priority_queue_top.sv
`timescale 1ns / 1ps
// min priority queue built as a sorted chain of cells
//
// cmd channel (sink): operation 0 enqueues entry_key/entry_tag, operation 1
// removes the entry with the smallest key; among equal keys the entry
// enqueued last comes out first. res channel (source): one result per
// request with accepted, the removed entry (zero unless a dequeue was done),
// the count after the request and the empty and full flags.
// apb port: register 0 at byte address 0 is capacity_limit (9 bits); a
// value above DEPTH acts as DEPTH. writes complete in the access cycle.
// the result is in the output register in the cycle after the request is
// taken. throughput: one request per cycle while results are taken; each
// request is a single parallel step of the cell chain (compare and shift
// in every cell). cmd.ready is high while the output register is empty or
// is being taken in the same cycle, so a stalled receiver holds the result
// and blocks new requests after at most one.
// reset: the queue is empty, capacity_limit is 256 and cmd.ready is held low;
// the cells need no clearing, only the first count cells are ever read.
module min_priority_queue_top #(
  parameter int DEPTH    = mpq_pkg::DEPTH_DEF,
  parameter int KEY_BITS = mpq_pkg::KEY_BITS_DEF,
  parameter int TAG_BITS = mpq_pkg::TAG_BITS_DEF,
  parameter int CNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  mpq_cmd_if.sink                            cmd,
  mpq_res_if.source                          res,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mpq_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [mpq_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [mpq_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);
  import mpq_pkg::*;

  // compare width that covers both the count and the limit register
  localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;
  localparam logic [CMP_BITS-1:0] DEPTH_CMP = CMP_BITS'(DEPTH);

  // config register
  logic [CAP_BITS-1:0]     capacity_limit;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_BITS-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (cfg_write && reg_idx == REG_CAPACITY_LIMIT) begin
      capacity_limit <= pwdata[CAP_BITS-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CAPACITY_LIMIT: prdata = APB_DATA_BITS'(capacity_limit);
      default:            prdata = '0;
    endcase
  end

  // effective limit, clipped to the chain length
  logic [CMP_BITS-1:0] cap_ext;
  logic [CMP_BITS-1:0] limit;
  assign cap_ext = CMP_BITS'(capacity_limit);
  assign limit   = (cap_ext > DEPTH_CMP) ? DEPTH_CMP : cap_ext;

  // request control
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;
  logic [CMP_BITS-1:0] count_ext;
  logic [CMP_BITS-1:0] count_next_ext;
  logic                take;
  logic                ins_ok;
  logic                del_ok;
  mpq_cmd_t            cell_cmd;

  logic                res_valid;
  logic                res_accepted;
  logic [KEY_BITS-1:0] res_key;
  logic [TAG_BITS-1:0] res_tag;
  logic [CNT_BITS-1:0] res_count;
  logic                res_empty;
  logic                res_full;

  assign cmd.ready = !rst && (!res_valid || res.ready);
  assign take      = cmd.valid && cmd.ready;
  assign count_ext = CMP_BITS'(count);

  assign ins_ok = (cmd.operation == OP_ENQUEUE) && (count_ext < limit);
  assign del_ok = (cmd.operation == OP_DEQUEUE) && (count != '0);

  assign cell_cmd.ins = take && ins_ok;
  assign cell_cmd.del = take && del_ok;

  always_comb begin
    count_next = count;
    if (cell_cmd.ins) begin
      count_next = count + CNT_BITS'(1);
    end else if (cell_cmd.del) begin
      count_next = count - CNT_BITS'(1);
    end
  end
  assign count_next_ext = CMP_BITS'(count_next);

  // the chain of cells, head (smallest key) in cell 0
  logic [KEY_BITS-1:0] cell_key  [DEPTH];
  logic [TAG_BITS-1:0] cell_tag  [DEPTH];
  logic                cell_flag [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] prev_key;
    logic [TAG_BITS-1:0] prev_tag;
    logic                prev_flag;
    logic [KEY_BITS-1:0] next_key;
    logic [TAG_BITS-1:0] next_tag;
    logic                occupied;

    if (i == 0) begin : g_head
      // the head has no predecessor, the new entry lands here when it wins
      assign prev_key  = cmd.entry_key;
      assign prev_tag  = cmd.entry_tag;
      assign prev_flag = 1'b0;
    end else begin : g_body
      assign prev_key  = cell_key[i-1];
      assign prev_tag  = cell_tag[i-1];
      assign prev_flag = cell_flag[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // tail drops out of the count on a dequeue, its content is don't-care
      assign next_key = cell_key[i];
      assign next_tag = cell_tag[i];
    end else begin : g_inner
      assign next_key = cell_key[i+1];
      assign next_tag = cell_tag[i+1];
    end

    assign occupied = count_ext > CMP_BITS'(i);

    mpq_cell #(
      .KEY_BITS (KEY_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk       (clk),
      .cmd       (cell_cmd),
      .occupied  (occupied),
      .new_key   (cmd.entry_key),
      .new_tag   (cmd.entry_tag),
      .prev_key  (prev_key),
      .prev_tag  (prev_tag),
      .prev_flag (prev_flag),
      .next_key  (next_key),
      .next_tag  (next_tag),
      .key       (cell_key[i]),
      .tag       (cell_tag[i]),
      .flag      (cell_flag[i])
    );
  end

  // count and output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (take) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload, captured with the request
  always_ff @(posedge clk) begin
    if (take) begin
      res_accepted <= ins_ok || del_ok;
      res_key      <= del_ok ? cell_key[0] : '0;
      res_tag      <= del_ok ? cell_tag[0] : '0;
      res_count    <= count_next;
      res_empty    <= (count_next == '0);
      res_full     <= (count_next_ext >= limit);
    end
  end

  assign res.valid    = res_valid;
  assign res.accepted = res_accepted;
  assign res.out_key  = res_key;
  assign res.out_tag  = res_tag;
  assign res.count    = res_count;
  assign res.is_empty = res_empty;
  assign res.is_full  = res_full;

endmodule

// File: src/mpq_checker.sv
`timescale 1ns / 1ps
module mpq_checker #(
  parameter int KEY_BITS = mpq_pkg::KEY_BITS_DEF,
  parameter int TAG_BITS = mpq_pkg::TAG_BITS_DEF,
  parameter int CNT_BITS = $clog2(mpq_pkg::DEPTH_DEF + 1)
) (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic                res_valid,
  input logic                res_ready,
  input logic                res_accepted,
  input logic [KEY_BITS-1:0] res_out_key,
  input logic [TAG_BITS-1:0] res_out_tag,
  input logic [CNT_BITS-1:0] res_count,
  input logic                res_is_empty
);
  import mpq_pkg::*;

  // a taken request shows its result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> res_valid)
    else $error("no result one cycle after request");

  // a refused request carries no entry
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_accepted |-> res_out_key == '0 && res_out_tag == '0)
    else $error("refused request returned an entry");

  // empty flag agrees with count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_is_empty == (res_count == '0))
    else $error("is_empty disagrees with count");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_out_key) && $stable(res_count))
    else $error("stalled result changed");

endmodule

bind min_priority_queue_top mpq_checker #(
  .KEY_BITS (KEY_BITS),
  .TAG_BITS (TAG_BITS),
  .CNT_BITS (CNT_BITS)
) u_mpq_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_accepted (res.accepted),
  .res_out_key  (res.out_key),
  .res_out_tag  (res.out_tag),
  .res_count    (res.count),
  .res_is_empty (res.is_empty)
);

// File: tb/sv/min_priority_queue_top_test.sv
`timescale 1ns / 1ps
module min_priority_queue_top_test;
  import mpq_pkg::*;

  localparam int CNT_BITS = $clog2(DEPTH_DEF + 1);
  // cycles without any accepted request or result before giving up
  localparam int STALL_LIMIT = 4000;
  // byte address that maps to no register
  localparam logic [APB_ADDR_BITS-1:0] ADDR_UNMAPPED = 3'd4;
  localparam logic [APB_ADDR_BITS-1:0] ADDR_CAPACITY = {REG_CAPACITY_LIMIT, 2'b00};

  typedef struct packed {
    logic                    accepted;
    logic [KEY_BITS_DEF-1:0] out_key;
    logic [TAG_BITS_DEF-1:0] out_tag;
    logic [CNT_BITS-1:0]     count;
    logic                    is_empty;
    logic                    is_full;
  } queue_result_t;

  // tracks the queue contents and the results still owed by the block
  class queue_scoreboard;
    logic [KEY_BITS_DEF-1:0] keys [DEPTH_DEF];
    logic [TAG_BITS_DEF-1:0] tags [DEPTH_DEF];
    int unsigned held;
    int unsigned capacity;
    queue_result_t awaited_results[$];
    int errors;
    int n_requests;
    int n_enqueued;
    int n_dequeued;
    int n_refused;
    int n_full;

    function new();
      held = 0;
      capacity = CAP_RESET;
      errors = 0;
      n_requests = 0;
      n_enqueued = 0;
      n_dequeued = 0;
      n_refused = 0;
      n_full = 0;
    endfunction

    function void set_capacity(int unsigned value);
      capacity = value & 32'h1FF;
    endfunction

    // apply one taken request and queue the result it must produce
    function void note_request(logic op, logic [KEY_BITS_DEF-1:0] key,
                               logic [TAG_BITS_DEF-1:0] tag);
      queue_result_t r;
      int unsigned lim;
      int unsigned best;
      lim = (capacity > DEPTH_DEF) ? DEPTH_DEF : capacity;
      r = '0;
      if (op == OP_ENQUEUE) begin
        if (held < lim) begin
          keys[held] = key;
          tags[held] = tag;
          held++;
          r.accepted = 1'b1;
          n_enqueued++;
        end
      end else if (held > 0) begin
        // smallest key, the latest inserted among equals
        best = 0;
        for (int i = 0; i < held; i++)
          if (keys[i] <= keys[best]) best = i;
        r.out_key = keys[best];
        r.out_tag = tags[best];
        for (int i = best; i + 1 < held; i++) begin
          keys[i] = keys[i + 1];
          tags[i] = tags[i + 1];
        end
        held--;
        r.accepted = 1'b1;
        n_dequeued++;
      end
      if (!r.accepted) n_refused++;
      r.count = CNT_BITS'(held);
      r.is_empty = (held == 0);
      r.is_full = (held >= lim);
      if (r.is_full) n_full++;
      n_requests++;
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none got %h", $time, got);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("out_key", want.out_key, got.out_key);
      compare_field("out_tag", want.out_tag, got.out_tag);
      compare_field("count", want.count, got.count);
      compare_field("is_empty", want.is_empty, got.is_empty);
      compare_field("is_full", want.is_full, got.is_full);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  mpq_cmd_if cmd_ch ();
  mpq_res_if res_ch ();

  min_priority_queue_top uut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  queue_scoreboard book = new();

  // percent of cycles in which the sender or the receiver holds back
  int src_idle_pct;
  int sink_idle_pct;
  int stall_cycles = 0;

  always #4 clk = ~clk;

  // receiver: take results and check them, then pick the next ready
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      book.check_result('{res_ch.accepted, res_ch.out_key, res_ch.out_tag,
                          res_ch.count, res_ch.is_empty, res_ch.is_full});
    res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, book.awaited_results.size());
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one request: random idle gaps, then hold valid until the block takes it
  task automatic send_request(input logic op, input logic [KEY_BITS_DEF-1:0] key,
                              input logic [TAG_BITS_DEF-1:0] tag);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.entry_key <= key;
    cmd_ch.entry_tag <= tag;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    book.note_request(op, key, tag);
  endtask

  // sender stops until every result owed has come back
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (book.awaited_results.size() != 0) @(posedge clk);
  endtask

  // one apb transfer: setup cycle, access cycle, done when pready is high
  task automatic apb_transfer(input logic wr, input logic [APB_ADDR_BITS-1:0] addr,
                              input logic [APB_DATA_BITS-1:0] wdata,
                              output logic [APB_DATA_BITS-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_capacity_readback();
    logic [APB_DATA_BITS-1:0] rdata;
    @(posedge clk);
    apb_transfer(1'b0, ADDR_CAPACITY, '0, rdata);
    if (rdata[CAP_BITS-1:0] != book.capacity[CAP_BITS-1:0]) begin
      $display("%0t: capacity_limit readback mismatch, expected %0d got %0d", $time,
               book.capacity, rdata[CAP_BITS-1:0]);
      book.errors++;
    end
  endtask

  // register writes only once the queue has nothing in flight
  task automatic reconfigure(input logic [APB_ADDR_BITS-1:0] addr, input int unsigned value);
    logic [APB_DATA_BITS-1:0] rdata;
    wait_drained();
    // allow a little slack after the last result before the write
    repeat (3) @(posedge clk);
    apb_transfer(1'b1, addr, value, rdata);
    if (addr == ADDR_CAPACITY) book.set_capacity(value);
    check_capacity_readback();
  endtask

  // keys lean toward ties and the two extremes
  function automatic logic [KEY_BITS_DEF-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: pick_key = $urandom_range(0, 7);
      1: pick_key = $urandom_range(0, 1) ? '1 : '0;
      default: pick_key = $urandom;
    endcase
  endfunction

  task automatic random_phase(input int unsigned cap, input int enq_pct, input int n);
    logic op;
    reconfigure(ADDR_CAPACITY, cap);
    for (int i = 0; i < n; i++) begin
      // now and then let the queue drain completely mid-stream
      if ($urandom_range(0, 49) == 0) wait_drained();
      op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
      send_request(op, pick_key(), TAG_BITS_DEF'($urandom_range(0, 511)));
    end
  endtask

  int unsigned phase_cap [8] = '{4, 256, 10, 511, 1, 0, 200, 256};
  int          phase_enq [8] = '{55, 90, 50, 30, 50, 50, 60, 20};
  int          phase_len [8] = '{60, 300, 40, 80, 50, 20, 100, 100};

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.operation <= OP_ENQUEUE;
    cmd_ch.entry_key <= '0;
    cmd_ch.entry_tag <= '0;
    src_idle_pct = 23;
    sink_idle_pct = 75;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // capacity_limit must come out of reset at its default
    check_capacity_readback();

    // dequeue when empty, extremes of key and tag, ties on the smallest key
    send_request(OP_DEQUEUE, '0, '0);
    send_request(OP_ENQUEUE, '0, '0);
    send_request(OP_ENQUEUE, '1, '1);
    send_request(OP_ENQUEUE, 32'd5, 9'd3);
    send_request(OP_ENQUEUE, 32'd5, 9'd4);
    send_request(OP_ENQUEUE, '0, 9'd17);
    repeat (6) send_request(OP_DEQUEUE, '1, '1);

    // capacity of one: second enqueue refused while full
    reconfigure(ADDR_CAPACITY, 1);
    send_request(OP_ENQUEUE, 32'h8000_0001, 9'h155);
    send_request(OP_ENQUEUE, 32'h0000_0001, 9'h0AA);
    send_request(OP_DEQUEUE, '0, '0);
    send_request(OP_DEQUEUE, '0, '0);

    // capacity of zero: always full, every enqueue refused
    reconfigure(ADDR_CAPACITY, 0);
    send_request(OP_ENQUEUE, 32'd9, 9'd9);
    send_request(OP_DEQUEUE, '0, '0);

    // limit lowered below the held count: enqueues refused until dequeues bring it under
    reconfigure(ADDR_CAPACITY, CAP_RESET);
    send_request(OP_ENQUEUE, 32'd30, 9'd1);
    send_request(OP_ENQUEUE, 32'd20, 9'd2);
    send_request(OP_ENQUEUE, 32'd10, 9'd3);
    reconfigure(ADDR_CAPACITY, 2);
    send_request(OP_ENQUEUE, 32'd1, 9'd4);
    send_request(OP_DEQUEUE, '0, '0);
    send_request(OP_DEQUEUE, '0, '0);
    send_request(OP_ENQUEUE, 32'd7, 9'd5);

    // limit above depth acts as depth; a write to an unmapped address is ignored
    reconfigure(ADDR_CAPACITY, 511);
    reconfigure(ADDR_UNMAPPED, 1);
    send_request(OP_ENQUEUE, 32'd2, 9'd6);

    // random traffic, three handshake idle patterns across the phases
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        src_idle_pct = 75;
        sink_idle_pct = 23;
      end else if (p == 6) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      random_phase(phase_cap[p], phase_enq[p], phase_len[p]);
    end

    wait_drained();
    repeat (5) @(posedge clk);

    $display("covered %0d requests: %0d enqueued, %0d dequeued, %0d refused, %0d ended full",
             book.n_requests, book.n_enqueued, book.n_dequeued, book.n_refused, book.n_full);
    $display("capacity limits 0, 1, 2, 4, 10, 200, 256 and 511 under three idle patterns");
    if (book.errors == 0 && book.awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/mpq_pkg.sv
src/mpq_if.sv
src/mpq_cell.sv
src/min_priority_queue_top.sv
src/mpq_checker.sv
tb/sv/min_priority_queue_top_test.sv
